### src/nbv_pkg.sv
package nbv_pkg;

  localparam int COUNT_W      = 12;
  localparam int PART_FIELD_W = 4;
  localparam int HOME_CODES   = 2 ** PART_FIELD_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic                    adjacent;
    logic [PART_FIELD_W-1:0] neighbor_part;
    logic                    row_last;
  } in_item_t;

  typedef struct packed {
    logic [PART_FIELD_W-1:0] dest_part;
    logic [COUNT_W-1:0]      proposal_num;
  } out_item_t;

  typedef struct packed {
    logic inc;
    logic clr_all;
  } bin_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_SWEEP,
    ST_LAST,
    ST_PICK,
    ST_PROP
  } vote_state_e;

endpackage

### src/nbv_stream_if.sv
interface nbv_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/nbv_bin_store.sv
module nbv_bin_store #(
  parameter int NUM_PARTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nbv_pkg::bin_ctl_t            ctl_i,
  input  logic [$clog2(NUM_PARTS)-1:0] addr_i,
  output logic [nbv_pkg::COUNT_W-1:0]  rd_o
);
  localparam int PART_W = $clog2(NUM_PARTS);

  logic [nbv_pkg::COUNT_W-1:0] mem_q [NUM_PARTS];
  logic [NUM_PARTS-1:0]        vld_q;

  logic [nbv_pkg::COUNT_W-1:0] rd_q;
  logic                        rvld_q;
  logic                        s_v_q;
  logic [PART_W-1:0]           s_a_q;
  logic                        w_v_q;
  logic [PART_W-1:0]           w_a_q;
  logic [nbv_pkg::COUNT_W-1:0] w_d_q;

  logic [nbv_pkg::COUNT_W-1:0] rd_val;
  logic [nbv_pkg::COUNT_W-1:0] cur_val;
  logic [nbv_pkg::COUNT_W-1:0] inc_val;

  assign rd_val = rvld_q ? rd_q : '0;
  // last write-back hit the entry this read missed
  assign cur_val = (w_v_q && (w_a_q == s_a_q)) ? w_d_q : rd_val;
  assign inc_val = (cur_val == nbv_pkg::COUNT_MAX) ? cur_val
                                                   : cur_val + nbv_pkg::COUNT_W'(1);
  assign rd_o = rd_val;

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[addr_i];
    if (s_v_q) begin
      mem_q[s_a_q] <= inc_val;
    end
    s_a_q <= addr_i;
    w_a_q <= s_a_q;
    w_d_q <= inc_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
      s_v_q  <= 1'b0;
      w_v_q  <= 1'b0;
    end else begin
      rvld_q <= vld_q[addr_i];
      s_v_q  <= ctl_i.inc;
      w_v_q  <= s_v_q;
      if (ctl_i.clr_all) begin
        vld_q <= '0;
      end else if (s_v_q) begin
        vld_q[s_a_q] <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_clr_during_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_v_q && ctl_i.clr_all))
    else $error("bin clear collides with pending write-back");
`endif

endmodule

### src/nbv_argmax.sv
module nbv_argmax #(
  parameter int NUM_PARTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  logic [$clog2(NUM_PARTS)-1:0] idx_i,
  input  logic [nbv_pkg::COUNT_W-1:0]  val_i,
  input  logic [$clog2(NUM_PARTS)-1:0] home_i,
  output logic [$clog2(NUM_PARTS)-1:0] dest_o
);
  localparam int PART_W = $clog2(NUM_PARTS);
  localparam logic [PART_W-1:0] LAST_IDX = PART_W'(NUM_PARTS - 1);

  logic [nbv_pkg::COUNT_W-1:0] max_q;
  logic [nbv_pkg::COUNT_W-1:0] home_val_q;
  logic [PART_W-1:0]           best_q;

  // first index holding the maximum; home wins if it ties the maximum
  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      if ((idx_i == '0) || (val_i > max_q)) begin
        max_q  <= val_i;
        best_q <= idx_i;
      end
      if (idx_i == home_i) begin
        home_val_q <= val_i;
      end
    end
  end

  assign dest_o = (home_val_q == max_q) ? home_i : best_q;

`ifndef SYNTHESIS
  a_home_not_above_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_i && (idx_i == LAST_IDX)) |=> (max_q >= home_val_q))
    else $error("home bin exceeds scanned maximum");
`endif

endmodule

### src/nbv_prop_store.sv
module nbv_prop_store #(
  parameter int NUM_PARTS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [$clog2(NUM_PARTS)-1:0] addr_i,
  input  logic                         upd_i,
  output logic [nbv_pkg::COUNT_W-1:0]  num_o
);
  logic [nbv_pkg::COUNT_W-1:0] mem_q [NUM_PARTS];
  logic [NUM_PARTS-1:0]        vld_q;
  logic [nbv_pkg::COUNT_W-1:0] rd_q;
  logic                        rvld_q;
  logic [nbv_pkg::COUNT_W-1:0] nxt_val;

  assign num_o   = rvld_q ? rd_q : '0;
  assign nxt_val = (num_o == nbv_pkg::COUNT_MAX) ? num_o
                                                 : num_o + nbv_pkg::COUNT_W'(1);

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[addr_i];
    if (upd_i) begin
      mem_q[addr_i] <= nxt_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[addr_i];
      if (upd_i) begin
        vld_q[addr_i] <= 1'b1;
      end
    end
  end

endmodule

### src/neighbor_partition_vote.sv
// Partition vote for one vertex row. Non-final row entries are taken one per
// cycle: each adjacent entry with an in-range partition updates its bin by a
// read-modify-write in a memory with a registered read, with the previous
// write-back forwarded so equal partitions may follow back to back. The entry
// flagged row_last closes the row, and ready then stays low (longer if the
// previous result has not been taken yet) through these steps: retiring the
// last bin update, a sweep that reads one bin per cycle from the single bin
// read port into a running argmax, letting the last bin read reach the argmax,
// picking the destination and reading its proposal counter, and loading the
// result register and writing the counter back.
// The bins are cleared at once through per-entry valid bits, so no clearing
// pass follows reset or a row. home_partition may only be written while idle.
module neighbor_partition_vote #(
  parameter int NUM_PARTS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [nbv_pkg::PART_FIELD_W-1:0]    cfg_wdata_i,
  nbv_stream_if.sink                          in_i,
  nbv_stream_if.source                        out_o
);
  localparam int PART_W = $clog2(NUM_PARTS);
  localparam int EXT_W  = 7;
  localparam logic [PART_W-1:0] LAST_IDX = PART_W'(NUM_PARTS - 1);

  nbv_pkg::vote_state_e state_q, state_d;
  logic [PART_W-1:0]    cnt_q, cnt_d;

  logic [nbv_pkg::PART_FIELD_W-1:0] home_q;
  logic [PART_W-1:0]                home_lut [nbv_pkg::HOME_CODES];
  logic [PART_W-1:0]                home_idx;

  logic [EXT_W-1:0]     part_ext;
  logic                 part_ok;
  logic                 in_fire;
  nbv_pkg::bin_ctl_t    bin_ctl;
  logic [PART_W-1:0]    bin_addr;
  logic [nbv_pkg::COUNT_W-1:0] bin_rd;

  logic                 scan_v_q;
  logic [PART_W-1:0]    scan_idx_q;
  logic [PART_W-1:0]    arg_dest;
  logic [PART_W-1:0]    dest_q;

  logic [PART_W-1:0]    prop_addr;
  logic                 prop_upd;
  logic [nbv_pkg::COUNT_W-1:0] prop_num;

  logic                 out_valid_q;
  nbv_pkg::out_item_t   out_data_q;

  for (genvar g = 0; g < nbv_pkg::HOME_CODES; g++) begin : g_home_lut
    assign home_lut[g] = PART_W'(g % NUM_PARTS);
  end
  assign home_idx = home_lut[home_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      home_q <= '0;
    end else if (cfg_we_i) begin
      home_q <= cfg_wdata_i;
    end
  end

  assign part_ext   = EXT_W'(in_i.data.neighbor_part);
  assign part_ok    = part_ext < EXT_W'(NUM_PARTS);
  assign in_i.ready = (state_q == nbv_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  assign bin_ctl.inc     = in_fire && in_i.data.adjacent && part_ok;
  assign bin_ctl.clr_all = (state_q == nbv_pkg::ST_PICK);
  assign bin_addr        = (state_q == nbv_pkg::ST_SWEEP) ? cnt_q : PART_W'(part_ext);

  assign prop_addr = (state_q == nbv_pkg::ST_PICK) ? arg_dest : dest_q;
  assign prop_upd  = (state_q == nbv_pkg::ST_PROP) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      nbv_pkg::ST_IDLE: begin
        if (in_fire && in_i.data.row_last) begin
          state_d = nbv_pkg::ST_DRAIN;
        end
      end
      nbv_pkg::ST_DRAIN: begin
        state_d = nbv_pkg::ST_SWEEP;
        cnt_d   = '0;
      end
      nbv_pkg::ST_SWEEP: begin
        if (cnt_q == LAST_IDX) begin
          state_d = nbv_pkg::ST_LAST;
        end else begin
          cnt_d = cnt_q + PART_W'(1);
        end
      end
      nbv_pkg::ST_LAST: begin
        state_d = nbv_pkg::ST_PICK;
      end
      nbv_pkg::ST_PICK: begin
        state_d = nbv_pkg::ST_PROP;
      end
      nbv_pkg::ST_PROP: begin
        if (prop_upd) begin
          state_d = nbv_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = nbv_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nbv_pkg::ST_IDLE;
      cnt_q       <= '0;
      scan_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      scan_v_q <= (state_q == nbv_pkg::ST_SWEEP);
      if (prop_upd) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= cnt_q;
    if (state_q == nbv_pkg::ST_PICK) begin
      dest_q <= arg_dest;
    end
    if (prop_upd) begin
      out_data_q.dest_part    <= nbv_pkg::PART_FIELD_W'(dest_q);
      out_data_q.proposal_num <= prop_num;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  nbv_bin_store #(.NUM_PARTS(NUM_PARTS)) u_bins (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (bin_ctl),
    .addr_i (bin_addr),
    .rd_o   (bin_rd)
  );

  nbv_argmax #(.NUM_PARTS(NUM_PARTS)) u_argmax (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (scan_v_q),
    .idx_i  (scan_idx_q),
    .val_i  (bin_rd),
    .home_i (home_idx),
    .dest_o (arg_dest)
  );

  nbv_prop_store #(.NUM_PARTS(NUM_PARTS)) u_props (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .addr_i (prop_addr),
    .upd_i  (prop_upd),
    .num_o  (prop_num)
  );

`ifndef SYNTHESIS
  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == nbv_pkg::ST_SWEEP) && (cnt_q == LAST_IDX)) |=>
      (state_q == nbv_pkg::ST_LAST))
    else $error("bin sweep did not end after last partition");
`endif

`ifndef SYNTHESIS
  a_result_not_overwritten: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == nbv_pkg::ST_PROP) && out_valid_q && !out_o.ready) |=>
      ((state_q == nbv_pkg::ST_PROP) && $stable(out_data_q)))
    else $error("pending result overwritten");
`endif

endmodule
